[design/literal_stream_find_replace_core_defines.svh]
// ----------------------------------------------------------------------------
// literal_stream_find_replace_core assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef LITERAL_STREAM_FIND_REPLACE_CORE_DEFINES_SVH
`define LITERAL_STREAM_FIND_REPLACE_CORE_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define LSFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Expression must never be true outside reset.
`define LSFR_NEVER(label, expr, msg) \
  `LSFR_ASSERT(label, !(expr), msg)

`endif

[design/lsfr_pkg.sv]
// ----------------------------------------------------------------------------
// lsfr_pkg
// Types and constants shared by the find/replace front, queue and back.
// ----------------------------------------------------------------------------
package lsfr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 64;   // pattern / replacement register
  localparam int unsigned LenW    = 4;    // length registers
  localparam int unsigned CntW    = 4;    // bytes per command, 0..8
  localparam int unsigned PosW    = 3;    // byte position inside a command
  localparam int unsigned TotalW  = 32;   // replacement counter
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ReplMax = 8;

  localparam logic [CfgIdxW-1:0] CfgPattern    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPatternLen = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRepl       = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgReplLen    = 2'd3;

  // What the back end emits for one command
  typedef enum logic [1:0] {
    CMD_REPL,   // cnt bytes of the replacement string
    CMD_SEQ,    // cnt original bytes: pattern prefix, then the input byte at pos
    CMD_MARK    // bare end-of-stream marker
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [CntW-1:0]   cnt;
    logic [PosW-1:0]   pos;
    logic [ByteW-1:0]  data;
    logic              last;
    logic [TotalW-1:0] total;
  } cmd_t;

endpackage

[design/literal_stream_find_replace_core.sv]
// ----------------------------------------------------------------------------
// literal_stream_find_replace_core
// Path: the front issues each command into the queue, and the back end
//   registers its bytes into the output register that drives tvalid.
// Throughput: one input byte per cycle while the queue is not full; the
//   bytes an input releases are absorbed by a QUEUE_DEPTH-entry command queue.
// Reset: async active low; clears held prefix, count, queue and output valid.
// ----------------------------------------------------------------------------
module literal_stream_find_replace_core import lsfr_pkg::*; #(
  parameter int unsigned MAX_PATTERN = 8,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input stream
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [7:0]               s_axis_tdata_i,  // [7:0] in_byte
  input  logic                     s_axis_tlast_i,  // is_last
  // output stream
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [39:0]              m_axis_tdata_o,  // [7:0] out_byte, [39:8] match_count
  output logic                     m_axis_tlast_o,  // run_last
  output logic [1:0]               m_axis_tuser_o,  // [0] has_byte, [1] stream_end
  // configuration writes
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [WordW-1:0]         cfg_data_i
);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; a write to either
  // pattern register drops any partially matched prefix.
  // --------------------------------------------------------------------------
  logic [WordW-1:0] pat_q, rep_q;
  logic [LenW-1:0]  plen_q, rlen_q;
  logic             cfg_wr, pat_flush;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign pat_flush   = cfg_wr && ((cfg_index_i == CfgPattern) ||
                                  (cfg_index_i == CfgPatternLen));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      plen_q <= LenW'(1);
      rep_q  <= '0;
      rlen_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        CfgPattern:    pat_q  <= cfg_data_i;
        CfgPatternLen: plen_q <= cfg_data_i[LenW-1:0];
        CfgRepl:       rep_q  <= cfg_data_i;
        CfgReplLen:    rlen_q <= cfg_data_i[LenW-1:0];
        default:       ;
      endcase
    end
  end

  // Effective lengths: zero pattern length acts as one, oversize values clamp.
  logic [LenW-1:0] plen_eff;
  logic [CntW-1:0] rlen_eff;

  always_comb begin
    if (plen_q == '0)                       plen_eff = LenW'(1);
    else if (plen_q > LenW'(MAX_PATTERN))   plen_eff = LenW'(MAX_PATTERN);
    else                                    plen_eff = plen_q;
    rlen_eff = (rlen_q > LenW'(ReplMax)) ? CntW'(ReplMax) : CntW'(rlen_q);
  end

  // --------------------------------------------------------------------------
  // Front end: classifies each byte against the held prefix and issues one
  // command per input transaction that produces output.
  // --------------------------------------------------------------------------
  logic accept, push, full, pop, head_valid;
  cmd_t cmd, head;

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  lsfr_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .byte_i    (s_axis_tdata_i),
    .last_i    (s_axis_tlast_i),
    .flush_i   (pat_flush),
    .pat_i     (pat_q),
    .pat_len_i (plen_eff),
    .rep_len_i (rlen_eff),
    .push_o    (push),
    .cmd_o     (cmd)
  );

  // Command queue decouples byte intake from multi-byte emission.
  lsfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid)
  );

  // --------------------------------------------------------------------------
  // Back end: walks each command one byte per cycle, while the output is not stalled, into the output register.
  // --------------------------------------------------------------------------
  logic [ByteW-1:0]  out_byte;
  logic              out_has, out_end;
  logic [TotalW-1:0] out_total;

  lsfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .pat_i        (pat_q),
    .rep_i        (rep_q),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .m_byte_o     (out_byte),
    .m_has_o      (out_has),
    .m_last_o     (m_axis_tlast_o),
    .m_end_o      (out_end),
    .m_total_o    (out_total)
  );

  assign m_axis_tdata_o = {out_total, out_byte};
  assign m_axis_tuser_o = {out_end, out_has};

endmodule

[design/lsfr_front.sv]
// ----------------------------------------------------------------------------
// lsfr_front
// Accepts stream bytes, tracks the held match prefix and issues commands.
// ----------------------------------------------------------------------------
module lsfr_front import lsfr_pkg::*; #(
  parameter int unsigned MAX_PATTERN = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [ByteW-1:0]  byte_i,
  input  logic              last_i,
  input  logic              flush_i,     // pattern rewritten, drop held bytes
  input  logic [WordW-1:0]  pat_i,
  input  logic [LenW-1:0]   pat_len_i,   // effective, 1..MAX_PATTERN
  input  logic [CntW-1:0]   rep_len_i,   // effective, 0..8
  output logic              push_o,
  output cmd_t              cmd_o
);

  localparam int unsigned HCW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // Held bytes always equal the first held_q pattern bytes, so only the count
  // is stored.
  logic [HCW-1:0]    held_q, held_d;
  logic [TotalW-1:0] total_q, total_d;

  logic [ByteW-1:0]       pbyte [MAX_PATTERN];
  logic [MAX_PATTERN:0]   ok;
  logic [CntW-1:0]        hx, shift, n;
  logic                   match;

  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      pbyte[k] = pat_i[k*ByteW +: ByteW];
    end
  end

  // ok[s]: after dropping s leading bytes, the rest is still a pattern prefix
  always_comb begin
    hx = CntW'(held_q);
    for (int s = 0; s <= MAX_PATTERN; s++) begin
      ok[s] = (CntW'(s) <= hx + CntW'(1));
      for (int i = s; i < MAX_PATTERN; i++) begin
        if ((CntW'(i) < hx) && (pbyte[i] != pbyte[i-s])) ok[s] = 1'b0;
      end
      for (int t = 0; t < MAX_PATTERN; t++) begin
        if ((CntW'(t + s) == hx) && (byte_i != pbyte[t])) ok[s] = 1'b0;
      end
    end
    shift = CntW'(MAX_PATTERN);
    for (int s = MAX_PATTERN; s >= 0; s--) begin
      if (ok[s]) shift = CntW'(s);
    end
    match = ok[0] && (hx + CntW'(1) == pat_len_i);
  end

  always_comb begin
    held_d        = held_q;
    total_d       = total_q;
    push_o        = 1'b0;
    n             = '0;
    cmd_o.kind    = CMD_SEQ;
    cmd_o.pos     = PosW'(held_q);
    cmd_o.data    = byte_i;
    cmd_o.last    = last_i;
    if (match) begin
      n       = rep_len_i;
      held_d  = '0;
      if (total_q != '1) total_d = total_q + TotalW'(1);
      cmd_o.kind = CMD_REPL;
      if (n == '0 && last_i) begin
        n          = CntW'(1);
        cmd_o.kind = CMD_MARK;
      end
    end else begin
      n      = last_i ? hx + CntW'(1) : shift;
      held_d = last_i ? '0 : HCW'(hx + CntW'(1) - shift);
    end
    cmd_o.cnt   = n;
    cmd_o.total = total_d;
    push_o      = accept_i && (n != '0);
    if (!accept_i) begin
      held_d  = held_q;
      total_d = total_q;
    end
    if (flush_i) held_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      total_q <= '0;
    end else begin
      held_q  <= held_d;
      total_q <= total_d;
    end
  end

endmodule

[design/lsfr_queue.sv]
// ----------------------------------------------------------------------------
// lsfr_queue
// Small command FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module lsfr_queue import lsfr_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t head_o,
  output logic head_valid_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] count_q, count_d;

  assign full_o       = (count_q == CW'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push_i) wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    if (pop_i)  rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    if (push_i && !pop_i) count_d = count_q + CW'(1);
    if (pop_i && !push_i) count_d = count_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule

[design/lsfr_back.sv]
// ----------------------------------------------------------------------------
// lsfr_back
// Expands queued commands into output bytes, one per cycle while the output is not stalled, into a register.
// ----------------------------------------------------------------------------
module lsfr_back import lsfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              head_i,
  input  logic              head_valid_i,
  output logic              pop_o,
  input  logic [WordW-1:0]  pat_i,
  input  logic [WordW-1:0]  rep_i,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [ByteW-1:0]  m_byte_o,
  output logic              m_has_o,
  output logic              m_last_o,
  output logic              m_end_o,
  output logic [TotalW-1:0] m_total_o
);

`include "literal_stream_find_replace_core_defines.svh"

  logic [PosW-1:0]   idx_q, idx_d;
  logic              m_valid_q, m_valid_d;
  logic [ByteW-1:0]  m_byte_q;
  logic              m_has_q, m_last_q, m_end_q;
  logic [TotalW-1:0] m_total_q;

  logic              load, item_last;
  logic [ByteW-1:0]  item_byte;

  assign load      = head_valid_i && (!m_valid_q || m_ready_i);
  assign item_last = (CntW'(idx_q) + CntW'(1) == head_i.cnt);
  assign pop_o     = load && item_last;

  always_comb begin
    case (head_i.kind)
      CMD_REPL: item_byte = rep_i[idx_q*ByteW +: ByteW];
      CMD_SEQ:  item_byte = (idx_q == head_i.pos) ? head_i.data
                                                  : pat_i[idx_q*ByteW +: ByteW];
      CMD_MARK: item_byte = '0;
      default:  item_byte = '0;
    endcase
  end

  always_comb begin
    idx_d     = idx_q;
    m_valid_d = m_valid_q;
    if (m_ready_i) m_valid_d = 1'b0;
    if (load) begin
      m_valid_d = 1'b1;
      idx_d     = item_last ? '0 : idx_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      m_byte_q  <= item_byte;
      m_has_q   <= (head_i.kind != CMD_MARK);
      m_last_q  <= item_last;
      m_end_q   <= item_last && head_i.last;
      m_total_q <= head_i.total;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_byte_o  = m_byte_q;
  assign m_has_o   = m_has_q;
  assign m_last_o  = m_last_q;
  assign m_end_o   = m_end_q;
  assign m_total_o = m_total_q;

  `LSFR_ASSERT(a_idx_in_range, head_valid_i |-> (CntW'(idx_q) < head_i.cnt), "index past command")
  `LSFR_NEVER(a_idx_orphan, (idx_q != '0) && !head_valid_i, "partial command lost")
  `LSFR_ASSERT(a_end_is_last, (m_valid_q && m_end_q) |-> m_last_q, "stream end without run last")

endmodule
